// ===== rtl/core/vgm_csp_pkg.sv =====
// Shared types, codes and opcode length table for the command stream parser.
package vgm_csp_pkg;

    localparam int OPS_DEPTH = 8;
    localparam int OPS_IDX_W = $clog2(OPS_DEPTH);

    localparam logic [31:0] START_POSITION_RESET = 32'd64;
    localparam logic        LONG_RESERVED_RESET  = 1'b1;
    localparam logic        LOOP_ENABLE_RESET    = 1'b0;
    localparam logic [31:0] LOOP_POSITION_RESET  = 32'd0;

    localparam logic [1:0] CFG_LONG_RESERVED = 2'd0;
    localparam logic [1:0] CFG_LOOP_ENABLE   = 2'd1;
    localparam logic [1:0] CFG_LOOP_POSITION = 2'd2;
    localparam logic [1:0] CFG_START_POS     = 2'd3;

    localparam logic [2:0] PH_OPCODE   = 3'd0;
    localparam logic [2:0] PH_OPERANDS = 3'd1;
    localparam logic [2:0] PH_ADDR     = 3'd2;
    localparam logic [2:0] PH_SKIP     = 3'd3;
    localparam logic [2:0] PH_HALT     = 3'd4;

    localparam logic [2:0] EV_REG_WRITE = 3'd0;
    localparam logic [2:0] EV_WAIT      = 3'd1;
    localparam logic [2:0] EV_LOOP_SEEK = 3'd2;
    localparam logic [2:0] EV_END       = 3'd3;
    localparam logic [2:0] EV_RAM_BLOCK = 3'd4;
    localparam logic [2:0] EV_ERROR     = 3'd5;

    localparam logic ERR_UNKNOWN_OPCODE = 1'b0;
    localparam logic ERR_EMPTY_BLOCK    = 1'b1;

    localparam logic [7:0] OP_WAIT_N     = 8'h61;
    localparam logic [7:0] OP_WAIT_735   = 8'h62;
    localparam logic [7:0] OP_WAIT_882   = 8'h63;
    localparam logic [7:0] OP_END        = 8'h66;
    localparam logic [7:0] OP_DATA_BLOCK = 8'h67;
    localparam logic [7:0] OP_REG_WRITE  = 8'hB4;
    localparam logic [3:0] OP_SHORT_WAIT = 4'h7;
    localparam logic [7:0] BLOCK_TYPE_RAM = 8'hC2;

    localparam logic [15:0] SAMPLES_735 = 16'd735;
    localparam logic [15:0] SAMPLES_882 = 16'd882;

    typedef struct packed {
        logic        write;
        logic [1:0]  index;
        logic [31:0] data;
    } cfg_write_t;

    typedef struct packed {
        logic [2:0]  event_kind;
        logic [7:0]  reg_index;
        logic [7:0]  reg_value;
        logic [15:0] wait_samples;
        logic [31:0] stream_position;
        logic [15:0] ram_address;
        logic [15:0] ram_length;
        logic        error_code;
    } event_t;

    function automatic logic op_known(input logic [7:0] op);
        logic known;
        known = 1'b1;
        if (op <= 8'h2F) known = 1'b0;
        else if (op == 8'h60 || op == 8'h64 || op == 8'h65) known = 1'b0;
        else if (op >= 8'h69 && op <= 8'h6F) known = 1'b0;
        else if (op >= 8'h96 && op <= 8'h9F) known = 1'b0;
        return known;
    endfunction

    function automatic logic [3:0] op_length(input logic [7:0] op, input logic long_res);
        logic [3:0] len;
        len = 4'd0;
        if (op >= 8'h30 && op <= 8'h3F) len = 4'd1;
        else if (op >= 8'h40 && op <= 8'h4E) len = long_res ? 4'd2 : 4'd1;
        else if (op == 8'h4F || op == 8'h50) len = 4'd1;
        else if (op >= 8'h51 && op <= 8'h5F) len = 4'd2;
        else if (op == OP_WAIT_N) len = 4'd2;
        else if (op == OP_DATA_BLOCK) len = 4'd6;
        else if (op == 8'h68) len = 4'd11;
        else if (op == 8'h90 || op == 8'h91 || op == 8'h95) len = 4'd4;
        else if (op == 8'h92) len = 4'd5;
        else if (op == 8'h93) len = 4'd10;
        else if (op == 8'h94) len = 4'd1;
        else if (op >= 8'hA0 && op <= 8'hBF) len = 4'd2;
        else if (op >= 8'hC0 && op <= 8'hDF) len = 4'd3;
        else if (op >= 8'hE0) len = 4'd4;
        return len;
    endfunction

endpackage

// ===== rtl/core/vgm_csp_parser.sv =====
// Parse state, configuration registers and per-byte decode of the command stream.
module vgm_csp_parser
    import vgm_csp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_write_t cfg,
    input  logic       byte_accept,
    input  logic [7:0] stream_byte,
    output logic       result_valid,
    output event_t     result
);

    logic [2:0]  phase_reg, phase_next;
    logic [7:0]  opcode_reg, opcode_next;
    logic [3:0]  count_reg, count_next;
    logic [31:0] skip_reg, skip_next;
    logic [31:0] pos_reg, pos_next;
    logic        loop_pending_reg, loop_pending_next;
    logic        long_res_reg, long_res_next;
    logic [31:0] loop_position_reg, loop_position_next;
    logic [7:0]  ops_reg [OPS_DEPTH];
    logic [7:0]  ops_cur [OPS_DEPTH];

    logic                 ops_we;
    logic [OPS_IDX_W-1:0] ops_widx;
    logic [31:0]          pos_inc;
    logic [3:0]           len;
    logic [3:0]           addr_count;
    logic [3:0]           count_inc;
    logic [31:0]          block_size;
    logic [31:0]          skip_dec;

    assign pos_inc    = pos_reg + 32'd1;
    assign len        = op_length(phase_reg == PH_OPCODE ? stream_byte : opcode_reg,
                                  long_res_reg);
    assign addr_count = (count_reg < 4'd6) ? 4'd6 : count_reg;
    assign block_size = {ops_cur[5], ops_cur[4], ops_cur[3], ops_cur[2]};
    assign skip_dec   = (skip_reg != 32'd0) ? skip_reg - 32'd1 : skip_reg;

    always_comb
    begin
        ops_we   = 1'b0;
        ops_widx = count_reg[OPS_IDX_W-1:0];
        if (byte_accept)
        begin
            if (phase_reg == PH_OPERANDS && count_reg < 4'(OPS_DEPTH))
            begin
                ops_we = 1'b1;
            end
            else if (phase_reg == PH_ADDR)
            begin
                ops_we   = 1'b1;
                ops_widx = addr_count[OPS_IDX_W-1:0];
            end
        end
        for (int i = 0; i < OPS_DEPTH; i++)
        begin
            ops_cur[i] = (ops_we && ops_widx == OPS_IDX_W'(i)) ? stream_byte : ops_reg[i];
        end
    end

    always_comb
    begin
        phase_next         = phase_reg;
        opcode_next        = opcode_reg;
        count_next         = count_reg;
        skip_next          = skip_reg;
        pos_next           = pos_reg;
        loop_pending_next  = loop_pending_reg;
        long_res_next      = long_res_reg;
        loop_position_next = loop_position_reg;
        count_inc          = 4'd0;
        result_valid       = 1'b0;
        result             = '0;

        if (byte_accept && phase_reg != PH_HALT)
        begin
            pos_next = pos_inc;
            case (phase_reg)
                PH_OPCODE:
                begin
                    if (!op_known(stream_byte))
                    begin
                        result_valid      = 1'b1;
                        result.event_kind = EV_ERROR;
                        result.error_code = ERR_UNKNOWN_OPCODE;
                        phase_next        = PH_HALT;
                    end
                    else if (len != 4'd0)
                    begin
                        opcode_next = stream_byte;
                        count_next  = 4'd0;
                        phase_next  = PH_OPERANDS;
                    end
                    else if (stream_byte == OP_WAIT_735 || stream_byte == OP_WAIT_882)
                    begin
                        result_valid        = 1'b1;
                        result.event_kind   = EV_WAIT;
                        result.wait_samples = (stream_byte == OP_WAIT_735) ?
                                              SAMPLES_735 : SAMPLES_882;
                    end
                    else if (stream_byte[7:4] == OP_SHORT_WAIT)
                    begin
                        result_valid        = 1'b1;
                        result.event_kind   = EV_WAIT;
                        result.wait_samples = {12'd0, stream_byte[3:0]} + 16'd1;
                    end
                    else if (stream_byte == OP_END)
                    begin
                        result_valid = 1'b1;
                        if (loop_pending_reg)
                        begin
                            loop_pending_next      = 1'b0;
                            pos_next               = loop_position_reg;
                            result.event_kind      = EV_LOOP_SEEK;
                            result.stream_position = loop_position_reg;
                        end
                        else
                        begin
                            result.event_kind = EV_END;
                            phase_next        = PH_HALT;
                        end
                    end
                end
                PH_OPERANDS:
                begin
                    count_inc  = count_reg + 4'd1;
                    count_next = count_inc;
                    if (count_inc >= len)
                    begin
                        phase_next = PH_OPCODE;
                        if (opcode_reg == OP_WAIT_N)
                        begin
                            result_valid        = 1'b1;
                            result.event_kind   = EV_WAIT;
                            result.wait_samples = {ops_cur[1], ops_cur[0]};
                        end
                        else if (opcode_reg == OP_REG_WRITE)
                        begin
                            result_valid      = 1'b1;
                            result.event_kind = EV_REG_WRITE;
                            result.reg_index  = ops_cur[0];
                            result.reg_value  = ops_cur[1];
                        end
                        else if (opcode_reg == OP_DATA_BLOCK)
                        begin
                            if (block_size == 32'd0)
                            begin
                                result_valid      = 1'b1;
                                result.event_kind = EV_ERROR;
                                result.error_code = ERR_EMPTY_BLOCK;
                                phase_next        = PH_HALT;
                            end
                            else if (ops_cur[1] == BLOCK_TYPE_RAM && block_size >= 32'd2)
                            begin
                                skip_next  = block_size - 32'd2;
                                phase_next = PH_ADDR;
                            end
                            else
                            begin
                                skip_next  = block_size;
                                phase_next = PH_SKIP;
                            end
                        end
                    end
                end
                PH_ADDR:
                begin
                    count_inc  = addr_count + 4'd1;
                    count_next = count_inc;
                    if (count_inc >= 4'(OPS_DEPTH))
                    begin
                        result_valid           = 1'b1;
                        result.event_kind      = EV_RAM_BLOCK;
                        result.stream_position = pos_inc;
                        result.ram_address     = {ops_cur[7], ops_cur[6]};
                        result.ram_length      = skip_reg[15:0];
                        phase_next = (skip_reg == 32'd0) ? PH_OPCODE : PH_SKIP;
                    end
                end
                PH_SKIP:
                begin
                    skip_next = skip_dec;
                    if (skip_dec == 32'd0)
                    begin
                        phase_next = PH_OPCODE;
                    end
                end
                default:
                begin
                    phase_next = PH_HALT;
                end
            endcase
        end

        if (cfg.write)
        begin
            case (cfg.index)
                CFG_LONG_RESERVED: long_res_next      = cfg.data[0];
                CFG_LOOP_ENABLE:   loop_pending_next  = cfg.data[0];
                CFG_LOOP_POSITION: loop_position_next = cfg.data;
                CFG_START_POS:     pos_next           = cfg.data;
                default:           long_res_next      = long_res_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_OPCODE;
            opcode_reg        <= 8'd0;
            count_reg         <= 4'd0;
            skip_reg          <= 32'd0;
            pos_reg           <= START_POSITION_RESET;
            loop_pending_reg  <= LOOP_ENABLE_RESET;
            long_res_reg      <= LONG_RESERVED_RESET;
            loop_position_reg <= LOOP_POSITION_RESET;
        end
        else
        begin
            phase_reg         <= phase_next;
            opcode_reg        <= opcode_next;
            count_reg         <= count_next;
            skip_reg          <= skip_next;
            pos_reg           <= pos_next;
            loop_pending_reg  <= loop_pending_next;
            long_res_reg      <= long_res_next;
            loop_position_reg <= loop_position_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ops_we)
        begin
            ops_reg[ops_widx] <= stream_byte;
        end
    end

endmodule

// ===== rtl/core/vgm_csp_out_reg.sv =====
// Output register that holds one event until the receiver takes it.
module vgm_csp_out_reg
    import vgm_csp_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   load,
    input  event_t load_data,
    input  logic   event_stall,
    output logic   event_valid,
    output event_t event_data
);

    logic   valid_reg, valid_next;
    event_t data_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (!event_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= load_data;
        end
    end

    assign event_valid = valid_reg;
    assign event_data  = data_reg;

endmodule

// ===== rtl/core/vgm_command_stream_parser_unit.sv =====
// Top level of the command stream parser: byte input, event output, config writes.
//
// The stream channel takes one command byte per transfer (stream_valid high,
// stream_stall low). Every byte is decoded in the cycle it is taken; when it
// completes a command that produces an event, the event is loaded into the
// output register and offered on the event channel in the next cycle.
// Throughput is one byte per cycle while stream_stall is low, set by the single
// parse-state update per byte. Bytes that only consume operands or skip data
// produce no transfer on the event channel.
// While an event waits under event_stall the register is full and stream_stall
// is held high, so no byte is taken until the event leaves; a new byte is taken
// in the same cycle the pending event is taken.
// After an end or error event all further bytes are taken and ignored until
// reset. Reset is asynchronous and active low; it empties the output register,
// restores the register defaults and loads the position counter with 64. Config
// writes are registered; the user must ensure they are made only while idle.
module vgm_command_stream_parser_unit
    import vgm_csp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        stream_valid,
    output logic        stream_stall,
    input  logic [7:0]  stream_byte,
    output logic        event_valid,
    input  logic        event_stall,
    output logic [2:0]  event_kind,
    output logic [7:0]  reg_index,
    output logic [7:0]  reg_value,
    output logic [15:0] wait_samples,
    output logic [31:0] stream_position,
    output logic [15:0] ram_address,
    output logic [15:0] ram_length,
    output logic        error_code
);

    cfg_write_t cfg;
    logic       byte_accept;
    logic       result_valid;
    event_t     result;
    event_t     event_data;

    assign cfg.write = cfg_write;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_data;

    assign stream_stall = event_valid && event_stall;
    assign byte_accept  = stream_valid && !stream_stall;

    vgm_csp_parser u_parser (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .byte_accept  (byte_accept),
        .stream_byte  (stream_byte),
        .result_valid (result_valid),
        .result       (result)
    );

    vgm_csp_out_reg u_out_reg (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (byte_accept && result_valid),
        .load_data   (result),
        .event_stall (event_stall),
        .event_valid (event_valid),
        .event_data  (event_data)
    );

    assign event_kind      = event_data.event_kind;
    assign reg_index       = event_data.reg_index;
    assign reg_value       = event_data.reg_value;
    assign wait_samples    = event_data.wait_samples;
    assign stream_position = event_data.stream_position;
    assign ram_address     = event_data.ram_address;
    assign ram_length      = event_data.ram_length;
    assign error_code      = event_data.error_code;

`ifndef ASSERT_OFF
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        stream_stall |-> event_valid)
        else $error("stream stalled without a pending event");

    a_error_code_only_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        (event_valid && event_kind != EV_ERROR) |-> (error_code == 1'b0))
        else $error("error code set on a non-error event");

    a_wait_fields_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (event_valid && event_kind == EV_WAIT) |->
        (reg_index == 8'd0 && ram_length == 16'd0 && stream_position == 32'd0))
        else $error("wait event carries stray fields");

    a_taken_event_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (event_valid && !event_stall && !stream_valid) |=> !event_valid)
        else $error("event stayed valid after transfer with no new byte");
`endif

endmodule
